// ===== rtl/cram_pkg.sv =====
`default_nettype none

package cram_pkg;

    // field widths of the channels and registers
    localparam int INDEX_FIELDS = 4;
    localparam int DIM_W        = 2;
    localparam int RANK_W       = 3;
    localparam int IDX_W        = 32;
    localparam int EXT_W        = 12;
    localparam int BYTES_W      = 5;
    localparam int OFFSET_W     = 52;
    localparam int KIND_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_W        = 12;

    // fault codes
    localparam logic [KIND_W-1:0] FAULT_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] FAULT_RANK   = 2'd1;
    localparam logic [KIND_W-1:0] FAULT_BOUNDS = 2'd2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_RANK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_0      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_1      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_3      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 3'd5;

    // register reset values
    localparam logic [RANK_W-1:0]  ARRAY_RANK_RST    = 3'd2;
    localparam logic [BYTES_W-1:0] ELEMENT_BYTES_RST = 5'd8;

    // fault report carried down the pipeline
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [DIM_W-1:0]        dim;
        logic signed [IDX_W-1:0] index;
        logic [EXT_W-1:0]        limit;
    } fault_t;

endpackage

`default_nettype wire

// ===== rtl/cram_ifs.sv =====
`default_nettype none

// access request channel
interface cram_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [cram_pkg::RANK_W-1:0]          subscript_rank;
    logic signed [cram_pkg::IDX_W-1:0]    index_0;
    logic signed [cram_pkg::IDX_W-1:0]    index_1;
    logic signed [cram_pkg::IDX_W-1:0]    index_2;
    logic signed [cram_pkg::IDX_W-1:0]    index_3;

    modport source (
        output valid, subscript_rank, index_0, index_1, index_2, index_3,
        input  ready
    );
    modport sink (
        input  valid, subscript_rank, index_0, index_1, index_2, index_3,
        output ready
    );
endinterface

// address result channel
interface cram_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [cram_pkg::OFFSET_W-1:0]        byte_offset;
    logic [cram_pkg::KIND_W-1:0]          fault_kind;
    logic [cram_pkg::DIM_W-1:0]           fault_dimension;
    logic signed [cram_pkg::IDX_W-1:0]    fault_index;
    logic [cram_pkg::EXT_W-1:0]           fault_limit;

    modport source (
        output valid, byte_offset, fault_kind, fault_dimension, fault_index,
               fault_limit,
        input  ready
    );
    modport sink (
        input  valid, byte_offset, fault_kind, fault_dimension, fault_index,
               fault_limit,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/cram_lane.sv =====
`default_nettype none

// bounds check of one dimension
module cram_lane (
    input  wire logic signed [cram_pkg::IDX_W-1:0] index,
    input  wire logic [cram_pkg::EXT_W-1:0]        extent,
    output logic                                   in_range
);

    // non-negative and strictly below the extent
    assign in_range = !index[cram_pkg::IDX_W-1]
        && (index[cram_pkg::IDX_W-2:0]
            < {{(cram_pkg::IDX_W-1-cram_pkg::EXT_W){1'b0}}, extent});

endmodule

`default_nettype wire

// ===== rtl/cram_merge.sv =====
`default_nettype none

// rank check and first-fault selection over the lane results
module cram_merge (
    input  wire logic [cram_pkg::RANK_W-1:0]         subscript_rank,
    input  wire logic [cram_pkg::RANK_W-1:0]         array_rank,
    input  wire logic                                rank_too_big,
    input  wire logic [cram_pkg::INDEX_FIELDS-1:0]   in_range,
    input  wire logic [cram_pkg::IDX_W-1:0]          index [cram_pkg::INDEX_FIELDS],
    input  wire logic [cram_pkg::EXT_W-1:0]          extent [cram_pkg::INDEX_FIELDS],
    output cram_pkg::fault_t                         fault
);

    logic found;

    always_comb
    begin
        fault = '0;
        found = 1'b0;
        if ((subscript_rank != array_rank) || rank_too_big)
        begin
            // rank mismatch reports both ranks
            fault.kind  = cram_pkg::FAULT_RANK;
            fault.index = {{(cram_pkg::IDX_W-cram_pkg::RANK_W){1'b0}}, subscript_rank};
            fault.limit = {{(cram_pkg::EXT_W-cram_pkg::RANK_W){1'b0}}, array_rank};
        end
        else
        begin
            // lowest active dimension out of range wins
            for (int d = 0; d < cram_pkg::INDEX_FIELDS; d++)
            begin
                if (!found && (d < int'(array_rank)) && !in_range[d])
                begin
                    found       = 1'b1;
                    fault.kind  = cram_pkg::FAULT_BOUNDS;
                    fault.dim   = cram_pkg::DIM_W'(d);
                    fault.index = index[d];
                    fault.limit = extent[d];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cram_mac.sv =====
`default_nettype none

// one horner step: acc * extent + index, or pass when beyond the rank
module cram_mac #(
    parameter int ACC_W = 12
) (
    input  wire logic [ACC_W-1:0]                  acc_in,
    input  wire logic [cram_pkg::EXT_W-1:0]        extent,
    input  wire logic [cram_pkg::EXT_W-1:0]        index,
    input  wire logic                              active,
    output logic [ACC_W+cram_pkg::EXT_W-1:0]       acc_out
);

    logic [ACC_W+cram_pkg::EXT_W-1:0] prod;

    assign prod = acc_in * extent;

    always_comb
    begin
        if (active)
            acc_out = prod + {{ACC_W{1'b0}}, index};
        else
            acc_out = {{cram_pkg::EXT_W{1'b0}}, acc_in};
    end

endmodule

`default_nettype wire

// ===== rtl/checked_row_major_address.sv =====
// result path: each request is registered through stages 1 to 5, and stage 5 drives the result
// throughput: one request per cycle; the five-stage pipeline moves as long as
//   results are taken, and a stalled result blocks only the stages behind it
// reset: pipeline emptied, array_rank 2, all extents 0, element_bytes 8
`default_nettype none

module checked_row_major_address #(
    parameter int MAX_RANK    = 4,
    parameter int EXTENT_BITS = 12
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [cram_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cram_pkg::CFG_W-1:0]       cfg_data,
    cram_req_if.sink                              req,
    cram_rsp_if.source                            rsp
);

    localparam int NSTAGE   = 5;
    localparam int KEEP_W   = (EXTENT_BITS < cram_pkg::EXT_W) ? EXTENT_BITS : cram_pkg::EXT_W;
    localparam logic [cram_pkg::EXT_W-1:0] EXT_MASK =
        cram_pkg::EXT_W'((64'd1 << KEEP_W) - 64'd1);
    localparam int EW  = cram_pkg::EXT_W;
    localparam int A1W = EW;
    localparam int A2W = 2 * EW;
    localparam int A3W = 3 * EW;
    localparam int A4W = 4 * EW;
    localparam int PW  = A4W + cram_pkg::BYTES_W;

    // configuration registers
    logic [cram_pkg::RANK_W-1:0]  array_rank_reg;
    logic [EW-1:0]                extent_reg [cram_pkg::INDEX_FIELDS];
    logic [cram_pkg::BYTES_W-1:0] element_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_rank_reg    <= cram_pkg::ARRAY_RANK_RST;
            element_bytes_reg <= cram_pkg::ELEMENT_BYTES_RST;
            for (int d = 0; d < cram_pkg::INDEX_FIELDS; d++)
            begin
                extent_reg[d] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cram_pkg::CFG_ARRAY_RANK:
                    array_rank_reg <= cfg_data[cram_pkg::RANK_W-1:0];
                cram_pkg::CFG_EXTENT_0:
                    extent_reg[0] <= cfg_data & EXT_MASK;
                cram_pkg::CFG_EXTENT_1:
                    extent_reg[1] <= cfg_data & EXT_MASK;
                cram_pkg::CFG_EXTENT_2:
                    extent_reg[2] <= cfg_data & EXT_MASK;
                cram_pkg::CFG_EXTENT_3:
                    extent_reg[3] <= cfg_data & EXT_MASK;
                cram_pkg::CFG_ELEMENT_BYTES:
                    element_bytes_reg <= cfg_data[cram_pkg::BYTES_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // pipeline flow control
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] en;

    always_comb
    begin
        en[NSTAGE-1] = !vld_reg[NSTAGE-1] || rsp.ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign req.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= req.valid;
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // bounds lanes, one per dimension
    logic [cram_pkg::IDX_W-1:0]        idx [cram_pkg::INDEX_FIELDS];
    logic [cram_pkg::INDEX_FIELDS-1:0] in_range;

    assign idx[0] = req.index_0;
    assign idx[1] = req.index_1;
    assign idx[2] = req.index_2;
    assign idx[3] = req.index_3;

    for (genvar d = 0; d < cram_pkg::INDEX_FIELDS; d++)
    begin : g_lane
        cram_lane u_lane (
            .index    (idx[d]),
            .extent   (extent_reg[d]),
            .in_range (in_range[d])
        );
    end

    // merge of the lane results
    logic             rank_too_big;
    cram_pkg::fault_t fault;

    assign rank_too_big = (int'(array_rank_reg) > MAX_RANK)
        || (int'(array_rank_reg) > cram_pkg::INDEX_FIELDS);

    cram_merge u_merge (
        .subscript_rank (req.subscript_rank),
        .array_rank     (array_rank_reg),
        .rank_too_big   (rank_too_big),
        .in_range       (in_range),
        .index          (idx),
        .extent         (extent_reg),
        .fault          (fault)
    );

    // stage 1: fault report and horner seed
    cram_pkg::fault_t s1_fault_reg;
    logic [A1W-1:0]   s1_acc_reg;
    logic [EW-1:0]    s1_idx1_reg;
    logic [EW-1:0]    s1_idx2_reg;
    logic [EW-1:0]    s1_idx3_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_fault_reg <= fault;
            s1_acc_reg   <= (array_rank_reg != '0) ? idx[0][EW-1:0] : '0;
            s1_idx1_reg  <= idx[1][EW-1:0];
            s1_idx2_reg  <= idx[2][EW-1:0];
            s1_idx3_reg  <= idx[3][EW-1:0];
        end
    end

    // stage 2: dimension one
    logic [A2W-1:0]   mac1;
    cram_pkg::fault_t s2_fault_reg;
    logic [A2W-1:0]   s2_acc_reg;
    logic [EW-1:0]    s2_idx2_reg;
    logic [EW-1:0]    s2_idx3_reg;

    cram_mac #(.ACC_W(A1W)) u_mac1 (
        .acc_in  (s1_acc_reg),
        .extent  (extent_reg[1]),
        .index   (s1_idx1_reg),
        .active  (array_rank_reg > cram_pkg::RANK_W'(1)),
        .acc_out (mac1)
    );

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_fault_reg <= s1_fault_reg;
            s2_acc_reg   <= mac1;
            s2_idx2_reg  <= s1_idx2_reg;
            s2_idx3_reg  <= s1_idx3_reg;
        end
    end

    // stage 3: dimension two
    logic [A3W-1:0]   mac2;
    cram_pkg::fault_t s3_fault_reg;
    logic [A3W-1:0]   s3_acc_reg;
    logic [EW-1:0]    s3_idx3_reg;

    cram_mac #(.ACC_W(A2W)) u_mac2 (
        .acc_in  (s2_acc_reg),
        .extent  (extent_reg[2]),
        .index   (s2_idx2_reg),
        .active  (array_rank_reg > cram_pkg::RANK_W'(2)),
        .acc_out (mac2)
    );

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_fault_reg <= s2_fault_reg;
            s3_acc_reg   <= mac2;
            s3_idx3_reg  <= s2_idx3_reg;
        end
    end

    // stage 4: dimension three
    logic [A4W-1:0]   mac3;
    cram_pkg::fault_t s4_fault_reg;
    logic [A4W-1:0]   s4_acc_reg;

    cram_mac #(.ACC_W(A3W)) u_mac3 (
        .acc_in  (s3_acc_reg),
        .extent  (extent_reg[3]),
        .index   (s3_idx3_reg),
        .active  (array_rank_reg > cram_pkg::RANK_W'(3)),
        .acc_out (mac3)
    );

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_fault_reg <= s3_fault_reg;
            s4_acc_reg   <= mac3;
        end
    end

    // stage 5: element size scaling into the output register
    logic [PW-1:0]                 scaled;
    logic [cram_pkg::OFFSET_W-1:0] offset_reg;
    cram_pkg::fault_t              out_fault_reg;

    assign scaled = s4_acc_reg * element_bytes_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            out_fault_reg <= s4_fault_reg;
            if (s4_fault_reg.kind == cram_pkg::FAULT_NONE)
                offset_reg <= scaled[cram_pkg::OFFSET_W-1:0];
            else
                offset_reg <= '0;
        end
    end

    // result channel
    assign rsp.valid           = vld_reg[NSTAGE-1];
    assign rsp.byte_offset     = offset_reg;
    assign rsp.fault_kind      = out_fault_reg.kind;
    assign rsp.fault_dimension = out_fault_reg.dim;
    assign rsp.fault_index     = out_fault_reg.index;
    assign rsp.fault_limit     = out_fault_reg.limit;

endmodule

`default_nettype wire
